// ===== design/bia_pkg.sv =====
// ---------------------------------------------------------------------------
// bia_pkg
// Shared types and constants for the bitmap ID allocator: map geometry,
// operation codes, the random-start constants and the map store request.
// ---------------------------------------------------------------------------
package bia_pkg;

  // Pool geometry: 256 IDs, eight IDs to a map word
  localparam int ID_W        = 8;
  localparam int BIT_SEL_W   = 3;
  localparam int WORD_BITS   = 8;
  localparam int MAP_WORDS   = 32;
  localparam int WORD_ADDR_W = 5;

  // Scan lengths (words for allocate first, IDs for allocate random)
  localparam logic [8:0] FIRST_SCAN_LEN = 9'd32;
  localparam logic [8:0] RAND_SCAN_LEN  = 9'd256;

  // Random start: stride between candidates and the seed multiplier
  localparam logic [ID_W-1:0] STRIDE    = 8'd31;
  localparam logic [ID_W-1:0] SEED_MULT = 8'd131;

  // Operation codes
  localparam logic [2:0] FN_CLEAR      = 3'd0;
  localparam logic [2:0] FN_RESERVE    = 3'd1;
  localparam logic [2:0] FN_OCCUPY     = 3'd2;
  localparam logic [2:0] FN_FREE       = 3'd3;
  localparam logic [2:0] FN_ALLOC_FST  = 3'd4;
  localparam logic [2:0] FN_ALLOC_RND  = 3'd5;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // One map word: reserved bits over occupied bits
  typedef struct packed {
    logic [WORD_BITS-1:0] reserved;
    logic [WORD_BITS-1:0] occupied;
  } map_word_t;

  // Request from the controller to the map store
  typedef struct packed {
    logic                   clear;
    logic [WORD_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [WORD_ADDR_W-1:0] wr_addr;
    map_word_t              wr_data;
  } map_req_t;

endpackage

// ===== design/bitmap_id_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// bitmap_id_allocator_unit
// Pool of 256 one-byte IDs tracked by occupied and reserved bitmaps.
// ---------------------------------------------------------------------------
// Each request (start high while busy is low) gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall it, so it must take
// every result as it comes. Clear and unused codes answer in the next cycle;
// reserve, occupy and free do a read-modify-write of one map word and answer
// from the modify state. Allocate first scans the 32 map words one per cycle
// over the single read port. Allocate random computes its start point in the
// seed state and then tests one candidate ID per cycle over the same port.
// Clear and reset empty the maps at once; there is no clearing pass. pool_seed
// is written through seed_we and seed_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module bitmap_id_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [7:0]  target_id,
  output logic        done,
  output logic [7:0]  alloc_id,
  output logic        status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SEED,
    S_SCAN
  } state_t;

  state_t                          state;
  logic [2:0]                      func_q;
  logic [bia_pkg::ID_W-1:0]        id_q;
  logic                            mode_first;
  logic [bia_pkg::ID_W-1:0]        cand_q;
  logic [8:0]                      issue_cnt;
  logic                            chk_valid;
  logic                            chk_last;
  logic [bia_pkg::ID_W-1:0]        chk_cand;
  logic [7:0]                      call_counter;
  logic [15:0]                     pool_seed;
  logic [15:0]                     seed_q;

  bia_pkg::map_req_t               map_req;
  bia_pkg::map_word_t              rd_word;
  bia_pkg::map_word_t              rmw_word;
  bia_pkg::map_word_t              hit_word;
  logic [bia_pkg::WORD_BITS-1:0]   free_mask;
  logic [bia_pkg::WORD_BITS-1:0]   rmw_mask;
  logic [bia_pkg::WORD_BITS-1:0]   hit_mask;
  logic [bia_pkg::BIT_SEL_W-1:0]   first_bit;
  logic [bia_pkg::BIT_SEL_W-1:0]   hit_bit;
  logic [bia_pkg::WORD_ADDR_W-1:0] hit_addr;
  logic                            hit;
  logic [8:0]                      scan_len;
  logic [bia_pkg::ID_W-1:0]        scan_step;
  logic [15:0]                     seed_prod;
  logic [bia_pkg::ID_W-1:0]        rand_start;
  logic [7:0]                      counter_next;

  assign busy = (state != S_IDLE);

  // Map store
  bia_map_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_word (rd_word)
  );

  // Find free IDs in the returned word; the lowest free bit wins
  assign free_mask = ~(rd_word.occupied | rd_word.reserved);

  always_comb begin
    first_bit = '0;
    for (int b = bia_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free_mask[b]) begin
        first_bit = b[bia_pkg::BIT_SEL_W-1:0];
      end
    end
  end

  assign hit_bit  = mode_first ? first_bit : chk_cand[bia_pkg::BIT_SEL_W-1:0];
  assign hit_addr = mode_first ? chk_cand[bia_pkg::WORD_ADDR_W-1:0]
                               : chk_cand[bia_pkg::ID_W-1:bia_pkg::BIT_SEL_W];
  assign hit      = chk_valid && (mode_first ? (free_mask != '0)
                                             : free_mask[chk_cand[2:0]]);
  assign hit_mask = bia_pkg::WORD_BITS'(1) << hit_bit;

  always_comb begin
    hit_word          = rd_word;
    hit_word.occupied = rd_word.occupied | hit_mask;
  end

  // Modify the addressed word for reserve, occupy and free
  assign rmw_mask = bia_pkg::WORD_BITS'(1) << id_q[bia_pkg::BIT_SEL_W-1:0];

  always_comb begin
    rmw_word = rd_word;
    case (func_q)
      bia_pkg::FN_RESERVE: rmw_word.reserved = rd_word.reserved | rmw_mask;
      bia_pkg::FN_OCCUPY:  rmw_word.occupied = rd_word.occupied | rmw_mask;
      bia_pkg::FN_FREE:    rmw_word.occupied = rd_word.occupied & ~rmw_mask;
      default:             rmw_word = rd_word;
    endcase
  end

  // Drive the map store
  always_comb begin
    map_req.clear   = (state == S_IDLE) && start && (func == bia_pkg::FN_CLEAR);
    map_req.rd_addr = (state == S_IDLE) ? target_id[7:3]
                    : (mode_first ? cand_q[bia_pkg::WORD_ADDR_W-1:0]
                                  : cand_q[bia_pkg::ID_W-1:bia_pkg::BIT_SEL_W]);
    map_req.wr_en   = (state == S_RMW) || ((state == S_SCAN) && hit);
    map_req.wr_addr = (state == S_RMW) ? id_q[bia_pkg::ID_W-1:bia_pkg::BIT_SEL_W]
                                       : hit_addr;
    map_req.wr_data = (state == S_RMW) ? rmw_word : hit_word;
  end

  // Scan length and step for the current allocate
  assign scan_len  = mode_first ? bia_pkg::FIRST_SCAN_LEN : bia_pkg::RAND_SCAN_LEN;
  assign scan_step = mode_first ? bia_pkg::ID_W'(1) : bia_pkg::STRIDE;

  // Random start from the low seed byte times the multiplier, xor the next byte
  assign seed_prod    = {8'd0, seed_q[7:0]} * {8'd0, bia_pkg::SEED_MULT};
  assign rand_start   = seed_prod[7:0] ^ seed_q[15:8];
  assign counter_next = call_counter + 8'd1;

  // Hold the seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_seed <= '0;
    end else if (seed_we) begin
      pool_seed <= seed_wdata[15:0];
    end
  end

  // Controller and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      chk_valid    <= 1'b0;
      call_counter <= '0;
      done         <= 1'b0;
      alloc_id     <= '0;
      status       <= bia_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            func_q    <= func;
            id_q      <= target_id;
            issue_cnt <= '0;
            chk_valid <= 1'b0;
            case (func)
              bia_pkg::FN_RESERVE, bia_pkg::FN_OCCUPY, bia_pkg::FN_FREE: begin
                state <= S_RMW;
              end
              bia_pkg::FN_ALLOC_FST: begin
                mode_first <= 1'b1;
                cand_q     <= '0;
                state      <= S_SCAN;
              end
              bia_pkg::FN_ALLOC_RND: begin
                mode_first   <= 1'b0;
                call_counter <= counter_next;
                seed_q       <= pool_seed + {8'd0, counter_next};
                state        <= S_SEED;
              end
              default: begin
                // clear and unused codes answer straight away
                done     <= 1'b1;
                alloc_id <= '0;
                status   <= bia_pkg::ST_OK;
              end
            endcase
          end
        end
        S_RMW: begin
          done     <= 1'b1;
          alloc_id <= '0;
          status   <= bia_pkg::ST_OK;
          state    <= S_IDLE;
        end
        S_SEED: begin
          cand_q <= rand_start;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            done      <= 1'b1;
            alloc_id  <= {hit_addr, hit_bit};
            status    <= bia_pkg::ST_OK;
            chk_valid <= 1'b0;
            state     <= S_IDLE;
          end else if (chk_valid && chk_last) begin
            done      <= 1'b1;
            alloc_id  <= '0;
            status    <= bia_pkg::ST_FULL;
            chk_valid <= 1'b0;
            state     <= S_IDLE;
          end else if (issue_cnt != scan_len) begin
            // advance to the next candidate while the last one is checked
            chk_valid <= 1'b1;
            chk_cand  <= cand_q;
            chk_last  <= (issue_cnt == scan_len - 9'd1);
            cand_q    <= cand_q + scan_step;
            issue_cnt <= issue_cnt + 9'd1;
          end else begin
            chk_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Results leave only once the controller is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result shown while busy");

  // A full pool reports ID zero
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == bia_pkg::ST_FULL)) |-> (alloc_id == '0))
    else $error("full result with nonzero ID");

  // Non-allocate requests either answer straight away or go to the modify state
  a_full_alloc: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func != bia_pkg::FN_ALLOC_FST)
     && (func != bia_pkg::FN_ALLOC_RND)) |=> (done || (state == S_RMW)))
    else $error("non-allocate request did not complete promptly");

  // Map writes happen only when modifying a word or taking a hit
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    map_req.wr_en |-> ((state == S_RMW) || (state == S_SCAN)))
    else $error("map write outside modify or scan");

  // A hit during the scan is followed by a successful result
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && hit) |=> (done && (status == bia_pkg::ST_OK)))
    else $error("hit did not give a successful result");

endmodule

// ===== design/bia_map_store.sv =====
// ---------------------------------------------------------------------------
// bia_map_store
// Occupied and reserved maps in one 32-word memory with a registered read.
// Per-word valid bits make a whole-map clear take effect at once.
// ---------------------------------------------------------------------------
module bia_map_store (
  input  logic                clk,
  input  logic                rst,
  input  bia_pkg::map_req_t   req,
  output bia_pkg::map_word_t  rd_word
);

  bia_pkg::map_word_t                mem [bia_pkg::MAP_WORDS];
  bia_pkg::map_word_t                rdata;
  logic [bia_pkg::MAP_WORDS-1:0]     valid;
  logic                              rd_ok;

  // Write and read the map memory
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rdata <= mem[req.rd_addr];
  end

  // Track written words; clear drops them all
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
    rd_ok <= valid[req.rd_addr];
  end

  // Read an unwritten word as empty
  assign rd_word = rd_ok ? rdata : '0;

endmodule

// ===== tb/tb_bitmap_id_allocator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bitmap_id_allocator_unit
// Self-checking bench for the bitmap ID allocator. A clocked driver feeds
// requests and seed writes from a pending list; a clocked monitor compares
// every result with the answer predicted from a shadow copy of both maps, the
// call counter and the pool seed. Stimulus runs a short directed part, then
// pool fill-up sequences and mixed traffic under several seed settings.
// ---------------------------------------------------------------------------
module tb_bitmap_id_allocator_unit;

  // Spare operation codes that the block must answer without a state change
  localparam logic [2:0]  FN_UNUSED_A = 3'd6;
  localparam logic [2:0]  FN_UNUSED_B = 3'd7;
  // Random start arithmetic
  localparam logic [7:0]  RND_STEP    = 8'd31;
  localparam logic [31:0] RND_MULT    = 32'd131;
  localparam int          ITEM_TARGET = 1650;
  localparam int          PHASES      = 6;
  localparam int          TAIL_CYCLES = 300;

  typedef enum logic [1:0] {OP_REQUEST, OP_SEED, OP_SETTLE} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [2:0]  fn;
    logic [7:0]  id;
    logic [31:0] seed;
  } op_entry_t;

  typedef struct packed {
    logic [7:0] id;
    logic       st;
  } answer_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        seed_we    = 1'b0;
  logic [31:0] seed_wdata = '0;
  logic        start      = 1'b0;
  logic [2:0]  func       = bia_pkg::FN_CLEAR;
  logic [7:0]  target_id  = '0;
  logic        busy;
  logic        done;
  logic [7:0]  alloc_id;
  logic        status;

  // Shadow pool state
  logic [255:0] pool_occ    = '0;
  logic [255:0] pool_rsv    = '0;
  logic [7:0]   rnd_calls   = '0;
  logic [31:0]  seed_shadow = '0;

  op_entry_t op_queue[$];
  answer_t   answer_q[$];
  int        n_accepted = 0;
  int        n_returned = 0;
  int        n_queued   = 0;
  int        n_errors   = 0;
  int        gap_left   = 0;
  int        hold_left  = 0;
  int        burst_left = 0;

  bitmap_id_allocator_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .target_id  (target_id),
    .done       (done),
    .alloc_id   (alloc_id),
    .status     (status)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (n_errors < 50) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  // Apply one request to the shadow pool and work out its answer
  function automatic void pool_apply(input logic [2:0] fn, input logic [7:0] id,
                                     output logic [7:0] got_id, output logic got_st);
    logic [31:0] mixed;
    logic [31:0] scaled;
    logic [7:0]  cand;
    logic        hit;
    got_id = '0;
    got_st = bia_pkg::ST_OK;
    hit    = 1'b0;
    case (fn)
      bia_pkg::FN_CLEAR: begin
        pool_occ = '0;
        pool_rsv = '0;
      end
      bia_pkg::FN_RESERVE: pool_rsv[id] = 1'b1;
      bia_pkg::FN_OCCUPY:  pool_occ[id] = 1'b1;
      bia_pkg::FN_FREE:    pool_occ[id] = 1'b0;
      bia_pkg::FN_ALLOC_FST: begin
        got_st = bia_pkg::ST_FULL;
        for (int i = 0; i < 256 && !hit; i++) begin
          if (!pool_occ[i] && !pool_rsv[i]) begin
            pool_occ[i] = 1'b1;
            got_id      = 8'(i);
            got_st      = bia_pkg::ST_OK;
            hit         = 1'b1;
          end
        end
      end
      bia_pkg::FN_ALLOC_RND: begin
        rnd_calls = rnd_calls + 8'd1;
        mixed     = seed_shadow + {24'd0, rnd_calls};
        scaled    = mixed * RND_MULT;
        cand      = scaled[7:0] ^ mixed[15:8];
        got_st    = bia_pkg::ST_FULL;
        for (int i = 0; i < 256 && !hit; i++) begin
          if (!pool_occ[cand] && !pool_rsv[cand]) begin
            pool_occ[cand] = 1'b1;
            got_id         = cand;
            got_st         = bia_pkg::ST_OK;
            hit            = 1'b1;
          end else begin
            cand = cand + RND_STEP;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_req(input logic [2:0] fn, input logic [7:0] id);
    op_queue.push_back('{OP_REQUEST, fn, id, 32'd0});
    n_queued++;
  endtask

  task automatic push_seed(input logic [31:0] value);
    op_queue.push_back('{OP_SEED, bia_pkg::FN_CLEAR, 8'd0, value});
  endtask

  task automatic push_settle();
    op_queue.push_back('{OP_SETTLE, bia_pkg::FN_CLEAR, 8'd0, 32'd0});
  endtask

  function automatic logic [7:0] any_id();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] any_alloc();
    return ($urandom_range(0, 1) != 0) ? bia_pkg::FN_ALLOC_RND : bia_pkg::FN_ALLOC_FST;
  endfunction

  // Clear, pre-load some reserves and occupants, allocate past full, then churn
  task automatic add_fill_sequence();
    int n_rsv;
    int n_occ;
    int n_alloc;
    int n_churn;
    push_req(bia_pkg::FN_CLEAR, any_id());
    n_rsv = $urandom_range(0, 40);
    repeat (n_rsv) push_req(bia_pkg::FN_RESERVE, any_id());
    n_occ = $urandom_range(0, 40);
    repeat (n_occ) push_req(bia_pkg::FN_OCCUPY, any_id());
    n_alloc = 256 - n_rsv - n_occ + $urandom_range(2, 6);
    repeat (n_alloc) push_req(any_alloc(), any_id());
    n_churn = $urandom_range(1, 6);
    repeat (n_churn) begin
      push_req(bia_pkg::FN_FREE, any_id());
      push_req(any_alloc(), any_id());
    end
    push_req(any_alloc(), any_id());
  endtask

  // Mixed traffic, mostly map updates and allocates
  task automatic add_mixed_sequence();
    int n_ops;
    int pick;
    n_ops = $urandom_range(20, 60);
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 2)       push_req(bia_pkg::FN_CLEAR, any_id());
      else if (pick < 4)  push_req(($urandom_range(0, 1) != 0) ? FN_UNUSED_A : FN_UNUSED_B,
                                   any_id());
      else if (pick < 20) push_req(bia_pkg::FN_RESERVE, any_id());
      else if (pick < 40) push_req(bia_pkg::FN_OCCUPY, any_id());
      else if (pick < 62) push_req(bia_pkg::FN_FREE, any_id());
      else if (pick < 81) push_req(bia_pkg::FN_ALLOC_FST, any_id());
      else                push_req(bia_pkg::FN_ALLOC_RND, any_id());
    end
  endtask

  // Driver: take requests, predict answers, feed the next pending entry
  always @(posedge clk) begin
    logic       nx_start;
    logic       nx_we;
    logic       took;
    int         nx_gap;
    int         nx_hold;
    logic [7:0] exp_id;
    logic       exp_st;
    op_entry_t  head;
    if (rst) begin
      start       <= 1'b0;
      seed_we     <= 1'b0;
      gap_left    <= 0;
      hold_left   <= 0;
      n_accepted  <= 0;
      pool_occ    = '0;
      pool_rsv    = '0;
      rnd_calls   = '0;
      seed_shadow = '0;
    end else begin
      nx_start = start;
      nx_we    = 1'b0;
      nx_gap   = gap_left;
      nx_hold  = hold_left;
      took     = start && !busy;
      if (took) begin
        pool_apply(func, target_id, exp_id, exp_st);
        answer_q.push_back('{exp_id, exp_st});
        n_accepted <= n_accepted + 1;
        nx_start = 1'b0;
        // draw the gap before the next request, with bursts of none
        if (burst_left > 0) begin
          burst_left--;
          nx_gap = 0;
        end else begin
          nx_gap = $urandom_range(0, 11);
          if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 40);
        end
      end
      // count down, then advance to the next pending entry
      if (!nx_start) begin
        if (nx_gap > 0) begin
          nx_gap--;
        end else if (nx_hold > 0) begin
          nx_hold--;
        end else if (op_queue.size() != 0) begin
          head = op_queue[0];
          case (head.kind)
            OP_REQUEST: begin
              nx_start = 1'b1;
              func      <= head.fn;
              target_id <= head.id;
              void'(op_queue.pop_front());
            end
            OP_SEED: begin
              if (!took && !busy && n_accepted == n_returned) begin
                nx_we = 1'b1;
                seed_wdata <= head.seed;
                seed_shadow = head.seed;
                void'(op_queue.pop_front());
              end
            end
            default: begin
              if (!took && n_accepted == n_returned) begin
                nx_hold = $urandom_range(5, 30);
                void'(op_queue.pop_front());
              end
            end
          endcase
        end
      end
      start     <= nx_start;
      seed_we   <= nx_we;
      gap_left  <= nx_gap;
      hold_left <= nx_hold;
    end
  end

  // Monitor: check each result against the oldest predicted answer
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      n_returned <= 0;
    end else if (done) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: id=%0d status=%0b",
                                  alloc_id, status));
      end else begin
        want = answer_q.pop_front();
        n_returned <= n_returned + 1;
        if (alloc_id !== want.id) begin
          report_mismatch($sformatf("result %0d: alloc_id %0d, expected %0d",
                                    n_returned, alloc_id, want.id));
        end
        if (status !== want.st) begin
          report_mismatch($sformatf("result %0d: status %0b, expected %0b",
                                    n_returned, status, want.st));
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] phase_seed;
    // directed: reset seed, reserve/free corner cases, spare codes, clear
    push_req(bia_pkg::FN_ALLOC_FST, 8'hFF);
    push_req(bia_pkg::FN_ALLOC_RND, 8'h00);
    push_req(bia_pkg::FN_RESERVE, 8'd0);
    push_req(bia_pkg::FN_RESERVE, 8'd255);
    push_req(bia_pkg::FN_OCCUPY, 8'd255);
    push_req(bia_pkg::FN_FREE, 8'd255);
    push_req(bia_pkg::FN_ALLOC_FST, 8'h00);
    push_req(bia_pkg::FN_FREE, 8'd0);
    push_req(bia_pkg::FN_ALLOC_FST, 8'h80);
    push_req(bia_pkg::FN_OCCUPY, 8'd3);
    push_req(bia_pkg::FN_ALLOC_FST, 8'h7F);
    push_req(FN_UNUSED_A, 8'hAA);
    push_req(FN_UNUSED_B, 8'h55);
    push_req(bia_pkg::FN_ALLOC_RND, 8'hFF);
    push_req(bia_pkg::FN_FREE, 8'd131);
    push_req(bia_pkg::FN_ALLOC_RND, 8'h01);
    push_req(bia_pkg::FN_CLEAR, 8'hFF);
    push_req(bia_pkg::FN_ALLOC_FST, 8'h00);
    push_req(bia_pkg::FN_RESERVE, 8'd1);
    push_req(bia_pkg::FN_ALLOC_FST, 8'h00);
    push_req(bia_pkg::FN_FREE, 8'd7);
    push_req(bia_pkg::FN_OCCUPY, 8'd0);
    push_settle();

    // random phases, each under its own seed
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_seed = 32'hFFFF_FFFF;
        1:       phase_seed = 32'h0000_0000;
        2:       phase_seed = 32'h8000_0000;
        4:       phase_seed = 32'h0000_FFF0;
        default: phase_seed = $urandom;
      endcase
      push_seed(phase_seed);
      add_fill_sequence();
      while (n_queued < ITEM_TARGET * (p + 1) / PHASES) add_mixed_sequence();
      if (p == 2) push_settle();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain everything, then watch for stray results
    while (op_queue.size() != 0 || start || n_accepted != n_returned) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));
    end
    if (n_errors == 0) begin
      $display("bitmap_id_allocator_unit verification clean");
    end else begin
      $display("bitmap_id_allocator_unit verification failed");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #30_000_000;
    $display("bitmap_id_allocator_unit verification failed");
    $finish;
  end

endmodule

// ===== bitmap_id_allocator_unit.f =====
design/bia_pkg.sv
design/bia_map_store.sv
design/bitmap_id_allocator_unit.sv
tb/tb_bitmap_id_allocator_unit.sv
